FILE: hw/rtl/euc_pkg.sv
// ----------------------------------------------------------------------------
// euc_pkg: shared constants and helpers of the epoch unique contact counter
// Widths of the bitmaps, the serial divider and the serial popcount.
// ----------------------------------------------------------------------------
package euc_pkg;

  // number of tracked peers, one bit per peer in every bitmap
  localparam int NODE_COUNT = 64;

  // time stamp and epoch length width
  localparam int TIME_W = 32;

  // width of the peer index and the community mask ports
  localparam int PEER_W = 6;
  localparam int MASK_W = 64;

  // result count width
  localparam int COUNT_W = 7;

  // popcount digit size and number of steps over the bitmap
  localparam int POP_DIGIT = 4;
  localparam int POP_STEPS = (NODE_COUNT + POP_DIGIT - 1) / POP_DIGIT;
  localparam int POP_WIDTH = POP_STEPS * POP_DIGIT;
  localparam int POP_STEP_W = $clog2(POP_STEPS + 1);
  localparam int POP_DIGIT_CW = $clog2(POP_DIGIT + 1);

  // divider step counter, holds TIME_W itself
  localparam int DIV_STEP_W = $clog2(TIME_W + 1);

  // event opcodes
  localparam logic [1:0] OP_CONNECT    = 2'd0;
  localparam logic [1:0] OP_DISCONNECT = 2'd1;
  localparam logic [1:0] OP_QUERY      = 2'd2;
  localparam logic [1:0] OP_UNUSED     = 2'd3;

  // reset value of the epoch length register
  localparam logic [TIME_W-1:0] EPOCH_LENGTH_RESET = TIME_W'(21600);

  // number of ones in one popcount digit
  function automatic logic [POP_DIGIT_CW-1:0] digit_ones(input logic [POP_DIGIT-1:0] d);
    logic [POP_DIGIT_CW-1:0] n;
    n = '0;
    for (int i = 0; i < POP_DIGIT; i++) begin
      n = n + POP_DIGIT_CW'(d[i]);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/euc_div.sv
// ----------------------------------------------------------------------------
// euc_div: bit-serial restoring divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module euc_div
  import euc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [TIME_W-1:0] dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [TIME_W-1:0] quotient,
  output logic [TIME_W-1:0] remainder
);

  logic [TIME_W-1:0]     quo;
  logic [TIME_W-1:0]     rem;
  logic [TIME_W-1:0]     dvs;
  logic [DIV_STEP_W-1:0] steps;
  logic                  busy;
  logic [TIME_W:0]       trial;
  logic                  fits;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem, quo[TIME_W-1]} - {1'b0, dvs};
  assign fits  = !trial[TIME_W];

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= DIV_STEP_W'(TIME_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      // zero length counts as one
      dvs <= (divisor == '0) ? TIME_W'(1) : divisor;
    end else if (busy) begin
      quo <= {quo[TIME_W-2:0], fits};
      rem <= fits ? trial[TIME_W-1:0] : {rem[TIME_W-2:0], quo[TIME_W-1]};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

FILE: hw/rtl/euc_popcnt.sv
// ----------------------------------------------------------------------------
// euc_popcnt: digit-serial popcount
// Shifts the loaded vector one small digit per cycle and sums its ones.
// ----------------------------------------------------------------------------
module euc_popcnt
  import euc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [POP_WIDTH-1:0] vec,
  output logic                 done,
  output logic [COUNT_W-1:0]   count
);

  logic [POP_WIDTH-1:0]  shreg;
  logic [POP_STEP_W-1:0] steps;
  logic                  busy;
  logic [COUNT_W-1:0]    acc;

  // control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= POP_STEP_W'(POP_STEPS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == POP_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: low digit counted, vector shifted down
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= vec;
      acc   <= '0;
    end else if (busy) begin
      shreg <= shreg >> POP_DIGIT;
      acc   <= acc + COUNT_W'(digit_ones(shreg[POP_DIGIT-1:0]));
    end
  end

  assign count = acc;

endmodule

FILE: hw/rtl/epoch_unique_contact_counter.sv
// ----------------------------------------------------------------------------
// epoch_unique_contact_counter: distinct peers met per time window
// Keeps connected, this-epoch and last-epoch peer bitmaps and answers
// rank queries with a masked count.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one event: opcode,
//   event_time, peer_index and community_mask. in_stall is high while an
//   event is in work; one event is handled at a time.
//   Output channel (out_valid / out_stall) carries rank_count and
//   time_error for queries and for events whose epoch went backwards.
//   Other connects and disconnects and opcode 3 give no result.
//   epoch_length is written through cfg_we / cfg_wdata; the user must
//   do so only while idle, as the block itself does not enforce it.
//   An event keeps in_stall high after its transfer while the divider
//   steps out epoch and remainder (S_DIV), hands them over and the
//   bitmaps update (S_UPD). A query then runs the 4-bit-per-cycle
//   popcount (S_CNT) and loads the output register from S_EMIT.
//   Opcode 3 never stalls the input.
// Reset (rst, synchronous): bitmaps and epochs clear, epoch_length = 21600.
// A stalled result stays in the output register; the next event is still
// taken and runs until its own result has to wait for the register.
// ----------------------------------------------------------------------------
module epoch_unique_contact_counter
  import euc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TIME_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [TIME_W-1:0]  event_time,
  input  logic [PEER_W-1:0]  peer_index,
  input  logic [MASK_W-1:0]  community_mask,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [COUNT_W-1:0] rank_count,
  output logic               time_error
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_UPD  = 5'b00100,
    S_CNT  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state;

  logic [TIME_W-1:0]     epoch_length;
  logic [NODE_COUNT-1:0] connected_now;
  logic [NODE_COUNT-1:0] seen_this_epoch;
  logic [NODE_COUNT-1:0] seen_last_epoch;
  logic [TIME_W-1:0]     epoch_current;
  logic [TIME_W-1:0]     epoch_previous;

  logic [NODE_COUNT-1:0] connected_now_next;
  logic [NODE_COUNT-1:0] seen_this_epoch_next;
  logic [NODE_COUNT-1:0] seen_last_epoch_next;
  logic [TIME_W-1:0]     epoch_current_next;
  logic [TIME_W-1:0]     epoch_previous_next;

  // latched event
  logic [1:0]            op;
  logic [PEER_W-1:0]     peer;
  logic [NODE_COUNT-1:0] mask;

  // result waiting for the output register
  logic [COUNT_W-1:0]    res_count;
  logic                  res_error;

  logic                  in_xfer;
  logic                  out_free;
  logic                  div_start;
  logic                  div_done;
  logic [TIME_W-1:0]     epoch_q;
  logic [TIME_W-1:0]     epoch_r;
  logic                  pop_start;
  logic                  pop_done;
  logic [COUNT_W-1:0]    pop_count;
  logic [POP_WIDTH-1:0]  pop_vec;
  logic                  back_in_time;
  logic [NODE_COUNT-1:0] peer_bit;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // epoch and remainder of the event time
  assign div_start = in_xfer && (opcode != OP_UNUSED);

  euc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (event_time),
    .divisor   (epoch_length),
    .done      (div_done),
    .quotient  (epoch_q),
    .remainder (epoch_r)
  );

  // masked count of the reported bitmap
  euc_popcnt u_pop (
    .clk   (clk),
    .rst   (rst),
    .start (pop_start),
    .vec   (pop_vec),
    .done  (pop_done),
    .count (pop_count)
  );

  // one-hot bit of the peer, none when out of range
  always_comb begin
    peer_bit = '0;
    if (32'(peer) < NODE_COUNT) begin
      peer_bit[peer] = 1'b1;
    end
  end

  // epoch roll-over and peer update
  assign back_in_time = (epoch_q < epoch_current);

  always_comb begin
    connected_now_next   = connected_now;
    seen_this_epoch_next = seen_this_epoch;
    seen_last_epoch_next = seen_last_epoch;
    epoch_current_next   = epoch_current;
    epoch_previous_next  = epoch_previous;
    if (!back_in_time) begin
      if (epoch_q > epoch_current) begin
        if ({1'b0, epoch_q} == {1'b0, epoch_current} + 1'b1) begin
          seen_last_epoch_next = seen_this_epoch;
          seen_this_epoch_next = connected_now;
          epoch_previous_next  = epoch_current;
        end else begin
          seen_last_epoch_next = connected_now;
          seen_this_epoch_next = connected_now;
          epoch_previous_next  = epoch_q - 1'b1;
        end
        epoch_current_next = epoch_q;
      end
      case (op)
        OP_CONNECT: begin
          connected_now_next   = connected_now_next | peer_bit;
          seen_this_epoch_next = seen_this_epoch_next | peer_bit;
        end
        OP_DISCONNECT: begin
          connected_now_next = connected_now_next & ~peer_bit;
          if (epoch_r != '0) begin
            seen_this_epoch_next = seen_this_epoch_next | peer_bit;
          end else begin
            seen_this_epoch_next = seen_this_epoch_next & ~peer_bit;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // query counts last epoch once an epoch has closed, else the current one
  assign pop_vec = (epoch_previous_next != epoch_current_next) ?
                   POP_WIDTH'(mask & seen_last_epoch_next) :
                   POP_WIDTH'(mask & seen_this_epoch_next);
  assign pop_start = (state == S_UPD) && !back_in_time && (op == OP_QUERY);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_length <= EPOCH_LENGTH_RESET;
    end else if (cfg_we) begin
      epoch_length <= cfg_wdata;
    end
  end

  // event latch
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op   <= opcode;
      peer <= peer_index;
      mask <= community_mask[NODE_COUNT-1:0];
    end
  end

  // sequencer and peer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      connected_now   <= '0;
      seen_this_epoch <= '0;
      seen_last_epoch <= '0;
      epoch_current   <= '0;
      epoch_previous  <= '0;
      res_count       <= '0;
      res_error       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (div_start) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          connected_now   <= connected_now_next;
          seen_this_epoch <= seen_this_epoch_next;
          seen_last_epoch <= seen_last_epoch_next;
          epoch_current   <= epoch_current_next;
          epoch_previous  <= epoch_previous_next;
          if (back_in_time) begin
            res_count <= '0;
            res_error <= 1'b1;
            state     <= S_EMIT;
          end else if (op == OP_QUERY) begin
            state <= S_CNT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_CNT: begin
          if (pop_done) begin
            res_count <= pop_count;
            res_error <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      rank_count <= res_count;
      time_error <= res_error;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("result appeared without a pending result");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  assert property (@(posedge clk) disable iff (rst)
    pop_done |-> (state == S_CNT))
    else $error("popcount finished outside the count phase");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && time_error) |-> (rank_count == '0))
    else $error("time error result carries a nonzero count");

  assert property (@(posedge clk) disable iff (rst)
    epoch_previous <= epoch_current)
    else $error("previous epoch is ahead of current epoch");

endmodule

FILE: test/contact_rank_checker.sv
// ----------------------------------------------------------------------------
// contact_rank_checker: result checker of the epoch unique contact counter
// Watches the configuration port and both channels, keeps its own copy of
// the peer bitmaps and epochs, and compares every result transfer with the
// oldest predicted rank.
// ----------------------------------------------------------------------------
module contact_rank_checker
  import euc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [TIME_W-1:0]  cfg_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [TIME_W-1:0]  event_time,
  input  logic [PEER_W-1:0]  peer_index,
  input  logic [MASK_W-1:0]  community_mask,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [COUNT_W-1:0] rank_count,
  input  logic               time_error,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic [COUNT_W-1:0] rank;
    logic               late;
  } rank_result_t;

  // predicted results, oldest first
  rank_result_t expected_ranks[$];

  // shadow of the block state and its one register
  logic [TIME_W-1:0]     epoch_len;
  logic [NODE_COUNT-1:0] connected;
  logic [NODE_COUNT-1:0] seen_cur;
  logic [NODE_COUNT-1:0] seen_prev;
  logic [TIME_W-1:0]     epoch_cur;
  logic [TIME_W-1:0]     epoch_prev;
  int                    mismatches = 0;

  function automatic logic [COUNT_W-1:0] count_selected(input logic [NODE_COUNT-1:0] v);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < NODE_COUNT; i++) begin
      n = n + COUNT_W'(v[i]);
    end
    return n;
  endfunction

  // apply one accepted event to the shadow state, queue its result if any
  task automatic track_event(input logic [1:0] op, input logic [TIME_W-1:0] t,
                             input logic [PEER_W-1:0] peer,
                             input logic [MASK_W-1:0] mask);
    logic [TIME_W-1:0]     len;
    logic [TIME_W-1:0]     ep;
    logic [TIME_W-1:0]     rem;
    logic [NODE_COUNT-1:0] peer_bit;
    logic [NODE_COUNT-1:0] sel;
    rank_result_t          r;
    len = (epoch_len == '0) ? TIME_W'(1) : epoch_len;
    ep = t / len;
    rem = t % len;
    peer_bit = (int'(peer) < NODE_COUNT) ? (NODE_COUNT'(1) << peer) : '0;
    sel = mask[NODE_COUNT-1:0];
    if (op == OP_UNUSED) begin
      // ignored entirely
    end else if (ep < epoch_cur) begin
      // epoch went backwards: flagged, state untouched
      r.rank = '0;
      r.late = 1'b1;
      expected_ranks.push_back(r);
    end else begin
      // epoch advance: shift by one window, reload on a gap
      if (ep > epoch_cur) begin
        if (ep == epoch_cur + 1) begin
          seen_prev = seen_cur;
          seen_cur = connected;
          epoch_prev = epoch_cur;
        end else begin
          seen_prev = connected;
          seen_cur = connected;
          epoch_prev = ep - 1;
        end
        epoch_cur = ep;
      end
      case (op)
        OP_CONNECT: begin
          connected = connected | peer_bit;
          seen_cur = seen_cur | peer_bit;
        end
        OP_DISCONNECT: begin
          connected = connected & ~peer_bit;
          if (rem != '0) seen_cur = seen_cur | peer_bit;
          else seen_cur = seen_cur & ~peer_bit;
        end
        default: begin
          r.rank = (epoch_prev != epoch_cur) ? count_selected(sel & seen_prev)
                                             : count_selected(sel & seen_cur);
          r.late = 1'b0;
          expected_ranks.push_back(r);
        end
      endcase
    end
  endtask

  // results are checked before new events are queued in the same cycle
  always @(posedge clk) begin : watch
    rank_result_t want;
    if (rst) begin
      epoch_len = EPOCH_LENGTH_RESET;
      connected = '0;
      seen_cur = '0;
      seen_prev = '0;
      epoch_cur = '0;
      epoch_prev = '0;
      expected_ranks.delete();
    end else begin
      if (cfg_we) epoch_len = cfg_wdata;
      // result transfer
      if (out_valid && !out_stall) begin
        if (expected_ranks.size() == 0) begin
          $error("unexpected result: rank_count %0d time_error %0d", rank_count, time_error);
          mismatches++;
        end else begin
          want = expected_ranks.pop_front();
          if (rank_count !== want.rank) begin
            $error("rank_count expected %0d actual %0d", want.rank, rank_count);
            mismatches++;
          end
          if (time_error !== want.late) begin
            $error("time_error expected %0d actual %0d", want.late, time_error);
            mismatches++;
          end
        end
      end
      // event transfer
      if (in_valid && !in_stall) begin
        track_event(opcode, event_time, peer_index, community_mask);
      end
    end
    fail_count <= mismatches;
    pending <= expected_ranks.size();
  end

endmodule

FILE: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: top of the epoch unique contact counter test
// Drives directed and random connect, disconnect and rank-query events over
// a range of epoch lengths with random gaps and stalls on both channels;
// the checker beside the block predicts and compares every rank.
// ----------------------------------------------------------------------------
module testbench;
  import euc_pkg::*;

  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int HOLD_AT       = 150;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 178;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [TIME_W-1:0]  cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         opcode;
  logic [TIME_W-1:0]  event_time;
  logic [PEER_W-1:0]  peer_index;
  logic [MASK_W-1:0]  community_mask;
  logic               out_valid;
  logic               out_stall;
  logic [COUNT_W-1:0] rank_count;
  logic               time_error;
  int                 fail_count;
  int                 pending;

  // stimulus bookkeeping
  bit                 no_idle = 1'b0;
  logic [TIME_W-1:0]  len_now = EPOCH_LENGTH_RESET;
  longint unsigned    now_t = 0;
  longint unsigned    top_epoch = 0;
  int                 cycle_count = 0;

  always #4 clk = ~clk;

  epoch_unique_contact_counter dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .event_time(event_time),
    .peer_index(peer_index),
    .community_mask(community_mask),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rank_count(rank_count),
    .time_error(time_error)
  );

  contact_rank_checker rank_check (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .event_time(event_time),
    .peer_index(peer_index),
    .community_mask(community_mask),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .rank_count(rank_count),
    .time_error(time_error),
    .fail_count(fail_count),
    .pending(pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint unsigned window_ticks();
    return (len_now == '0) ? 64'd1 : 64'(len_now);
  endfunction

  // offer one event after a random gap and wait for its transfer
  task automatic send_event(input logic [1:0] op, input logic [TIME_W-1:0] t,
                            input logic [PEER_W-1:0] peer,
                            input logic [MASK_W-1:0] mask);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    event_time <= t;
    peer_index <= peer;
    community_mask <= mask;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op != OP_UNUSED && 64'(t) / window_ticks() > top_epoch) begin
      top_epoch = 64'(t) / window_ticks();
    end
  endtask

  // write the epoch length once the block has drained
  task automatic write_epoch_length(input logic [TIME_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_now = value;
    if (now_t < top_epoch * window_ticks()) now_t = top_epoch * window_ticks();
  endtask

  // one random event around the current window
  task automatic random_event(output logic [1:0] op);
    logic [PEER_W-1:0] peer;
    logic [MASK_W-1:0] mask;
    longint unsigned   len;
    longint unsigned   ep;
    longint unsigned   off;
    longint unsigned   t;
    int                pick;
    len = window_ticks();
    ep = now_t / len;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_CONNECT;
    else if (pick < 57) op = OP_DISCONNECT;
    else if (pick < 95) op = OP_QUERY;
    else op = OP_UNUSED;
    // favor a few peers so disconnects often hit connected ones
    peer = ($urandom_range(0, 1) == 0) ? PEER_W'($urandom_range(0, 7)) : PEER_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 2) mask = '1;
    else if (pick < 3) mask = '0;
    else if (pick < 7) mask = {$urandom, $urandom};
    else mask = {$urandom, $urandom} & {$urandom, $urandom};
    // same window, next window, a gap, the same tick, or backwards
    off = ($urandom_range(0, 3) == 0) ? 64'd0 : 64'($urandom) % len;
    pick = $urandom_range(0, 99);
    if (pick < 45) t = ep * len + off;
    else if (pick < 75) t = (ep + 1) * len + off;
    else if (pick < 85) t = (ep + 64'($urandom_range(2, 5))) * len + off;
    else if (pick < 93) t = now_t;
    else t = ((ep > 3) ? ep - 64'($urandom_range(1, 3)) : 64'd0) * len + off;
    if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
    if (t > now_t) now_t = t;
    send_event(op, TIME_W'(t), peer, mask);
  endtask

  // result side: random stalls, one long hold-off to back the block up
  initial begin : result_sink
    int gap;
    int taken;
    taken = 0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // event side
  initial begin : stimulus
    logic [TIME_W-1:0] phase_len [PHASES];
    logic [1:0]        op_sent;
    int                sent;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    opcode <= OP_CONNECT;
    event_time <= '0;
    peer_index <= '0;
    community_mask <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed, reset epoch length: first window
    send_event(OP_QUERY, 32'd0, 6'd0, '1);
    send_event(OP_DISCONNECT, 32'd0, 6'd2, '0);
    send_event(OP_CONNECT, 32'd5, 6'd0, '0);
    send_event(OP_CONNECT, 32'd10, 6'd63, '0);
    send_event(OP_CONNECT, 32'd100, 6'd5, '0);
    send_event(OP_DISCONNECT, 32'd300, 6'd5, '0);
    send_event(OP_UNUSED, 32'd0, 6'd7, '1);
    send_event(OP_QUERY, 32'd400, 6'd0, '1);
    send_event(OP_QUERY, 32'd400, 6'd0, '0);
    send_event(OP_QUERY, 32'd400, 6'd0, 64'h8000_0000_0000_0001);
    // next window, then an earlier tick inside it, then a drop in epoch
    send_event(OP_CONNECT, 32'd21700, 6'd9, '0);
    send_event(OP_QUERY, 32'd21650, 6'd0, '1);
    send_event(OP_CONNECT, 32'd5, 6'd1, '1);

    // directed, longest window
    write_epoch_length(32'hFFFF_FFFF);
    send_event(OP_CONNECT, 32'hFFFF_FFFF, 6'd62, '0);
    send_event(OP_QUERY, 32'hFFFF_FFFF, 6'd0, '1);
    send_event(OP_DISCONNECT, 32'hFFFF_FFFF, 6'd62, '0);
    send_event(OP_QUERY, 32'h7FFF_FFFF, 6'd0, '1);

    // directed, zero length acts as one tick
    write_epoch_length(32'd0);
    send_event(OP_QUERY, 32'd1, 6'd0, '1);
    send_event(OP_DISCONNECT, 32'd2, 6'd9, '0);
    send_event(OP_QUERY, 32'd3, 6'd0, '1);
    send_event(OP_CONNECT, 32'd40, 6'd33, '0);
    send_event(OP_QUERY, 32'd41, 6'd0, 64'h5555_5555_5555_5555);
    send_event(OP_QUERY, 32'd41, 6'd0, '1);

    // random phases; the last one runs near the top of the time range
    phase_len = '{32'd1000003, 32'd21600, 32'd4999, TIME_W'($urandom_range(2, 300)),
                  32'd97, 32'd1, 32'd0, 32'd7};
    for (int p = 0; p < PHASES; p++) begin
      write_epoch_length(phase_len[p]);
      if (p == PHASES - 1 && now_t < 64'hFFFF_F800) now_t = 64'hFFFF_F800;
      no_idle = (p == 2 || p == 5);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        random_event(op_sent);
        if (op_sent != OP_UNUSED) sent++;
      end
    end

    // drain
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
